>>> rtl/dbwc_pkg.sv
// Shared widths, constants and register codes for the delay-based window controller.
// No dependencies.
package dbwc_pkg;

  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int MARGIN_W    = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int WIN_W    = 24;
  localparam int WIN_FRAC = 16;
  localparam logic [WIN_W-1:0] WIN_MAX   = 24'hFFFFFF;
  localparam logic [WIN_W-1:0] WIN_RESET = 24'h320000;

  localparam int LEAST_W = 7;
  localparam logic [LEAST_W-1:0] LEAST_RESET = 7'd100;
  localparam int LEAST_SHIFT = 23;

  localparam int GAP_W  = 32;
  localparam int AVG_W  = 40;
  localparam int AVG_FRAC = 8;
  localparam logic [AVG_W-1:0] AVG_RESET = 40'd256;

  localparam int QUO_W     = 33;
  localparam int DIV_STEPS = 33;
  localparam int STEP_W    = 6;
  localparam logic [QUO_W-1:0] RECIP_NUM = 33'h1_0000_0000;

  localparam logic [COUNT_W-1:0]  MIN_WINDOW_RESET  = 8'd1;
  localparam logic [COUNT_W-1:0]  MAX_WINDOW_RESET  = 8'd35;
  localparam logic [COUNT_W-1:0]  QUEUE_FLOOR_RESET = 8'd10;
  localparam logic [MARGIN_W-1:0] RTT_MARGIN_RESET  = 10'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_WINDOW  = 3'd0,
    REG_MAX_WINDOW  = 3'd1,
    REG_QUEUE_FLOOR = 3'd2,
    REG_RTT_MARGIN  = 3'd3
  } cfg_reg_t;

endpackage

>>> rtl/dbwc_if.sv
// Valid/ready channels of the window controller: acknowledgement in, window out.
// Depends on dbwc_pkg.
interface dbwc_ack_if;
  logic                        valid;
  logic                        ready;
  logic [dbwc_pkg::TIME_W-1:0] send_time;
  logic [dbwc_pkg::TIME_W-1:0] ack_time;
  modport source (output valid, output send_time, output ack_time, input ready);
  modport sink (input valid, input send_time, input ack_time, output ready);
endinterface

interface dbwc_win_if;
  logic                         valid;
  logic                         ready;
  logic [dbwc_pkg::COUNT_W-1:0] window_count;
  logic                         queue_seen;
  modport source (output valid, output window_count, output queue_seen, input ready);
  modport sink (input valid, input window_count, input queue_seen, output ready);
endinterface

>>> rtl/delay_based_window_controller.sv
// Delay-based congestion window controller, top level.
// Depends on dbwc_pkg and the channel interfaces in dbwc_if.sv.
// One acknowledgement is processed at a time: ack.ready is low from acceptance until the
// result is loaded into the output register. Processing runs the 33-step restoring
// divider shared by the reciprocal and the queueing-case quotient.
// Reset (synchronous, active high) restores registers and controller state.
module delay_based_window_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dbwc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  dbwc_ack_if.sink                        ack,
  dbwc_win_if.source                      win
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_LEAST = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_AVG   = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int THR_W = dbwc_pkg::MARGIN_W + 1;

  state_t state;

  logic [dbwc_pkg::COUNT_W-1:0]  min_window;
  logic [dbwc_pkg::COUNT_W-1:0]  max_window;
  logic [dbwc_pkg::COUNT_W-1:0]  queue_floor;
  logic [dbwc_pkg::MARGIN_W-1:0] rtt_margin;

  logic [dbwc_pkg::WIN_W-1:0]   window;
  logic [dbwc_pkg::LEAST_W-1:0] least;
  logic [TIME_BITS-1:0]         prev_ack;
  logic [dbwc_pkg::AVG_W-1:0]   gap_avg;

  logic [TIME_BITS-1:0]       send_q;
  logic [TIME_BITS-1:0]       ack_q;
  logic [TIME_BITS-1:0]       rtt;
  logic [TIME_BITS-1:0]       gap;
  logic [dbwc_pkg::GAP_W-1:0] gap_sat;
  logic                       queue;
  logic                       win_zero;

  logic [dbwc_pkg::AVG_W-1:0]  rem;
  logic [dbwc_pkg::QUO_W-1:0]  dq;
  logic [dbwc_pkg::AVG_W-1:0]  dvs;
  logic [dbwc_pkg::STEP_W-1:0] count;

  logic [dbwc_pkg::COUNT_W-1:0] out_window;
  logic                         out_queue;
  logic                         out_valid;

  logic [TIME_BITS+dbwc_pkg::TIME_W-1:0] send_ext;
  logic [TIME_BITS+dbwc_pkg::TIME_W-1:0] ack_ext;
  logic [TIME_BITS+dbwc_pkg::GAP_W-1:0]  gap_ext;
  logic [TIME_BITS-1:0]                  gap_raw;
  logic [THR_W-1:0]                      thr;
  logic [dbwc_pkg::AVG_W-1:0]            gq;
  logic [dbwc_pkg::AVG_W:0]              avg_sum;
  logic [dbwc_pkg::AVG_W:0]              shifted;
  logic [dbwc_pkg::AVG_W:0]              trial;
  logic [dbwc_pkg::QUO_W:0]              add_a;
  logic [dbwc_pkg::QUO_W:0]              add_b;
  logic [dbwc_pkg::QUO_W:0]              add_sum;
  logic [dbwc_pkg::WIN_W-1:0]            win_clamped;

  function automatic logic [dbwc_pkg::WIN_W-1:0] clamp_win(
    input logic [dbwc_pkg::WIN_W-1:0]   w,
    input logic [dbwc_pkg::COUNT_W-1:0] lo,
    input logic [dbwc_pkg::COUNT_W-1:0] hi
  );
    logic [dbwc_pkg::WIN_W-1:0] hi_f;
    logic [dbwc_pkg::WIN_W-1:0] lo_f;
    logic [dbwc_pkg::WIN_W-1:0] r;
    hi_f = {hi, {dbwc_pkg::WIN_FRAC{1'b0}}};
    lo_f = {lo, {dbwc_pkg::WIN_FRAC{1'b0}}};
    r = w;
    if (r > hi_f) r = hi_f;
    if (r < lo_f) r = lo_f;
    return r;
  endfunction

  assign send_ext = {{TIME_BITS{1'b0}}, ack.send_time};
  assign ack_ext  = {{TIME_BITS{1'b0}}, ack.ack_time};
  assign gap_raw  = ack_q - prev_ack;
  assign gap_ext  = {{dbwc_pkg::GAP_W{1'b0}}, gap};
  assign thr      = {{(THR_W-dbwc_pkg::LEAST_W){1'b0}}, least} + {1'b0, rtt_margin};
  assign gq       = {gap_sat, {dbwc_pkg::AVG_FRAC{1'b0}}};
  assign avg_sum  = {1'b0, gap_avg} + {1'b0, gq};
  assign shifted  = {rem, dq[dbwc_pkg::QUO_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign win_clamped = clamp_win(window, min_window, max_window);

  always_comb begin
    if (queue) begin
      add_a = {1'b0, dq};
      add_b = {{(dbwc_pkg::QUO_W+1-dbwc_pkg::WIN_W){1'b0}}, queue_floor,
               {dbwc_pkg::WIN_FRAC{1'b0}}};
    end else begin
      add_a = {{(dbwc_pkg::QUO_W+1-dbwc_pkg::WIN_W){1'b0}}, window};
      if (win_zero) begin
        add_b = {{(dbwc_pkg::QUO_W+1-dbwc_pkg::WIN_W){1'b0}}, dbwc_pkg::WIN_MAX};
      end else begin
        add_b = {1'b0, dq};
      end
    end
    add_sum = add_a + add_b;
  end

  assign ack.ready        = (state == S_IDLE);
  assign win.valid        = out_valid;
  assign win.window_count = out_window;
  assign win.queue_seen   = out_queue;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_window  <= dbwc_pkg::MIN_WINDOW_RESET;
      max_window  <= dbwc_pkg::MAX_WINDOW_RESET;
      queue_floor <= dbwc_pkg::QUEUE_FLOOR_RESET;
      rtt_margin  <= dbwc_pkg::RTT_MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dbwc_pkg::REG_MIN_WINDOW:  min_window  <= cfg_data[dbwc_pkg::COUNT_W-1:0];
        dbwc_pkg::REG_MAX_WINDOW:  max_window  <= cfg_data[dbwc_pkg::COUNT_W-1:0];
        dbwc_pkg::REG_QUEUE_FLOOR: queue_floor <= cfg_data[dbwc_pkg::COUNT_W-1:0];
        dbwc_pkg::REG_RTT_MARGIN:  rtt_margin  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      window    <= dbwc_pkg::WIN_RESET;
      least     <= dbwc_pkg::LEAST_RESET;
      prev_ack  <= '0;
      gap_avg   <= dbwc_pkg::AVG_RESET;
    end else begin
      if (out_valid && win.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ack.valid) begin
            send_q <= send_ext[TIME_BITS-1:0];
            ack_q  <= ack_ext[TIME_BITS-1:0];
            state  <= S_DIFF;
          end
        end
        S_DIFF: begin
          window <= win_clamped;
          rtt    <= ack_q - send_q;
          gap    <= (gap_raw == '0) ? {{(TIME_BITS-1){1'b0}}, 1'b1} : gap_raw;
          state  <= S_LEAST;
        end
        S_LEAST: begin
          if (rtt < {{(TIME_BITS-dbwc_pkg::LEAST_W){1'b0}}, least}) begin
            least <= rtt[dbwc_pkg::LEAST_W-1:0];
          end
          // gaps beyond 32 bits saturate
          if (gap_ext[TIME_BITS+dbwc_pkg::GAP_W-1:dbwc_pkg::GAP_W] != '0) begin
            gap_sat <= '1;
          end else begin
            gap_sat <= gap_ext[dbwc_pkg::GAP_W-1:0];
          end
          prev_ack <= ack_q;
          state    <= S_EVAL;
        end
        S_EVAL: begin
          queue <= (rtt >= {{(TIME_BITS-THR_W){1'b0}}, thr});
          state <= S_AVG;
        end
        S_AVG: begin
          if (queue) begin
            if (gq > gap_avg) begin
              gap_avg <= gq;
            end else begin
              gap_avg <= avg_sum[dbwc_pkg::AVG_W:1];
            end
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          rem   <= '0;
          count <= '0;
          if (queue) begin
            dq  <= {{(dbwc_pkg::QUO_W-dbwc_pkg::LEAST_W-dbwc_pkg::LEAST_SHIFT){1'b0}},
                    least, {dbwc_pkg::LEAST_SHIFT{1'b0}}};
            dvs <= (gap_avg == '0) ? {{(dbwc_pkg::AVG_W-1){1'b0}}, 1'b1} : gap_avg;
          end else begin
            dq  <= dbwc_pkg::RECIP_NUM;
            dvs <= {{(dbwc_pkg::AVG_W-dbwc_pkg::WIN_W){1'b0}}, window};
          end
          win_zero <= (window == '0);
          state    <= S_DIV;
        end
        S_DIV: begin
          if (!trial[dbwc_pkg::AVG_W]) begin
            rem <= trial[dbwc_pkg::AVG_W-1:0];
            dq  <= {dq[dbwc_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem <= shifted[dbwc_pkg::AVG_W-1:0];
            dq  <= {dq[dbwc_pkg::QUO_W-2:0], 1'b0};
          end
          count <= count + 1'b1;
          if (count == dbwc_pkg::STEP_W'(dbwc_pkg::DIV_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (add_sum > {{(dbwc_pkg::QUO_W+1-dbwc_pkg::WIN_W){1'b0}}, dbwc_pkg::WIN_MAX}) begin
            window <= dbwc_pkg::WIN_MAX;
          end else begin
            window <= add_sum[dbwc_pkg::WIN_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || win.ready) begin
            window     <= win_clamped;
            out_window <= win_clamped[dbwc_pkg::WIN_W-1:dbwc_pkg::WIN_FRAC];
            out_queue  <= queue;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/dbwc_checker.sv
// Port-level checks for the window controller, bound to the top level.
// Depends on dbwc_pkg and delay_based_window_controller.
module dbwc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dbwc_pkg::COUNT_W-1:0] window_count,
  input logic                         queue_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(window_count) && $stable(queue_seen))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_busy_through_divide: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##20 !in_ready)
    else $error("ready returned before divide finished");

endmodule

bind delay_based_window_controller dbwc_checker u_dbwc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (ack.valid),
  .in_ready     (ack.ready),
  .out_valid    (win.valid),
  .out_ready    (win.ready),
  .window_count (win.window_count),
  .queue_seen   (win.queue_seen)
);

>>> tb/sv/tb_top.sv
// Testbench for delay_based_window_controller: acknowledgement transactions in,
// window transactions out, checked against an in-bench window predictor.
// Depends on dbwc_pkg, dbwc_ack_if / dbwc_win_if and the controller RTL.
module tb_top;
  import dbwc_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] send_time;
    logic [TIME_W-1:0] ack_time;
  } ack_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] window_count;
    logic               queue_seen;
  } win_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dbwc_ack_if ack_ch ();
  dbwc_win_if win_ch ();

  delay_based_window_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ack       (ack_ch),
    .win       (win_ch)
  );

  // predictor copy of registers and controller state
  longint unsigned min_win_cfg   = MIN_WINDOW_RESET;
  longint unsigned max_win_cfg   = MAX_WINDOW_RESET;
  longint unsigned floor_cfg     = QUEUE_FLOOR_RESET;
  longint unsigned margin_cfg    = RTT_MARGIN_RESET;
  longint unsigned win_q8_16     = WIN_RESET;
  longint unsigned least_rtt_ms  = LEAST_RESET;
  logic [TIME_W-1:0] last_ack_ms = '0;
  longint unsigned gap_avg_q32_8 = AVG_RESET;

  ack_item_t   pending_acks[$];
  win_result_t expected_windows[$];
  ack_item_t   next_ack;
  win_result_t got_window;
  win_result_t want_window;

  logic [TIME_W-1:0] ack_clock;
  bit              ack_taken;
  bit              quiet;
  int unsigned     ack_pause;
  int unsigned     win_stall;
  int unsigned     acks_sent;
  int unsigned     windows_checked;
  int unsigned     queue_hits;
  int unsigned     settings_used;
  int unsigned     mismatches;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic void clamp_window();
    if (win_q8_16 > (max_win_cfg << WIN_FRAC)) win_q8_16 = max_win_cfg << WIN_FRAC;
    if (win_q8_16 < (min_win_cfg << WIN_FRAC)) win_q8_16 = min_win_cfg << WIN_FRAC;
  endfunction

  function automatic longint unsigned sat_window(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > longint'(WIN_MAX)) ? longint'(WIN_MAX) : s;
  endfunction

  function automatic win_result_t advance_window(logic [TIME_W-1:0] send_ms,
                                                 logic [TIME_W-1:0] ack_ms);
    logic [TIME_W-1:0] rtt_raw;
    logic [TIME_W-1:0] gap_raw;
    longint unsigned   rtt;
    longint unsigned   gap;
    longint unsigned   gap_q;
    longint unsigned   recip;
    bit                queued;
    win_result_t       r;
    clamp_window();
    rtt_raw = ack_ms - send_ms;
    gap_raw = ack_ms - last_ack_ms;
    rtt = rtt_raw;
    gap = (gap_raw == '0) ? 1 : gap_raw;
    if (rtt < least_rtt_ms) least_rtt_ms = rtt;
    queued = (rtt - least_rtt_ms) >= margin_cfg;
    if (!queued) begin
      recip = (win_q8_16 == 0) ? longint'(WIN_MAX) : (64'h1_0000_0000 / win_q8_16);
      win_q8_16 = sat_window(win_q8_16, recip);
    end else begin
      gap_q = gap << AVG_FRAC;
      if (gap_q > gap_avg_q32_8) gap_avg_q32_8 = gap_q;
      else gap_avg_q32_8 = (gap_avg_q32_8 + gap_q) >> 1;
      win_q8_16 = sat_window((least_rtt_ms << LEAST_SHIFT) / gap_avg_q32_8,
                             floor_cfg << WIN_FRAC);
    end
    clamp_window();
    last_ack_ms = ack_ms;
    r.window_count = win_q8_16[WIN_FRAC +: COUNT_W];
    r.queue_seen   = queued;
    return r;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // acknowledgement driver
  always @(negedge clk) begin
    if (rst) begin
      ack_ch.valid <= 1'b0;
    end else if (!ack_ch.valid || ack_taken) begin
      if (ack_pause != 0) begin
        ack_pause--;
        ack_ch.valid <= 1'b0;
      end else if (pending_acks.size() != 0) begin
        next_ack = pending_acks.pop_front();
        ack_ch.valid     <= 1'b1;
        ack_ch.send_time <= next_ack.send_time;
        ack_ch.ack_time  <= next_ack.ack_time;
        ack_pause = pick_pause();
      end else begin
        ack_ch.valid <= 1'b0;
      end
    end
  end

  // window sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      win_ch.ready <= 1'b0;
    end else if (win_stall != 0) begin
      win_stall--;
      win_ch.ready <= 1'b0;
    end else begin
      win_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) win_stall = pick_pause();
    end
  end

  // monitor: predict on each accepted ack, check each accepted window
  always @(posedge clk) begin
    ack_taken = !rst && ack_ch.valid && ack_ch.ready;
    if (ack_taken) begin
      expected_windows.push_back(advance_window(ack_ch.send_time, ack_ch.ack_time));
      acks_sent++;
    end
    if (!rst && win_ch.valid && win_ch.ready) begin
      got_window.window_count = win_ch.window_count;
      got_window.queue_seen   = win_ch.queue_seen;
      if (expected_windows.size() == 0) begin
        $error("unexpected window transaction: window_count %0d queue_seen %0d",
               got_window.window_count, got_window.queue_seen);
        mismatches++;
      end else begin
        want_window = expected_windows.pop_front();
        if (got_window.window_count !== want_window.window_count) begin
          $error("window_count: expected %0d, actual %0d",
                 want_window.window_count, got_window.window_count);
          mismatches++;
        end
        if (got_window.queue_seen !== want_window.queue_seen) begin
          $error("queue_seen: expected %0d, actual %0d",
                 want_window.queue_seen, got_window.queue_seen);
          mismatches++;
        end
        if (want_window.queue_seen) queue_hits++;
        windows_checked++;
      end
    end
  end

  task automatic push_ack(input logic [TIME_W-1:0] send_ms, input logic [TIME_W-1:0] ack_ms);
    ack_item_t it;
    it.send_time = send_ms;
    it.ack_time  = ack_ms;
    pending_acks.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_acks.size() != 0 || ack_ch.valid || expected_windows.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MIN_WINDOW:  min_win_cfg = val[COUNT_W-1:0];
      REG_MAX_WINDOW:  max_win_cfg = val[COUNT_W-1:0];
      REG_QUEUE_FLOOR: floor_cfg   = val[COUNT_W-1:0];
      REG_RTT_MARGIN:  margin_cfg  = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned min_w, input int unsigned max_w,
                                input int unsigned floor_w, input int unsigned margin);
    wait_drained();
    write_reg(REG_MIN_WINDOW, CFG_DATA_W'(min_w));
    write_reg(REG_MAX_WINDOW, CFG_DATA_W'(max_w));
    write_reg(REG_QUEUE_FLOOR, CFG_DATA_W'(floor_w));
    write_reg(REG_RTT_MARGIN, CFG_DATA_W'(margin));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly steady ack streams around base_rtt; some noise and out-of-order acks
  task automatic queue_acks(input int unsigned count, input int unsigned base_rtt);
    int unsigned r;
    int unsigned step;
    int unsigned rtt;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 70) step = $urandom_range(0, 20);
        else if (r < 95) step = $urandom_range(21, 500);
        else step = $urandom_range(501, 100000);
        ack_clock += step;
        rtt = base_rtt + $urandom_range(0, 32'(margin_cfg + margin_cfg / 2 + 3));
        push_ack(ack_clock - rtt, ack_clock);
      end else if (r < 93) begin
        ack_clock = $urandom;
        push_ack($urandom, ack_clock);
      end else begin
        ack_clock -= $urandom_range(1, 1000);
        push_ack(ack_clock + $urandom_range(1, 1000), ack_clock);
      end
    end
  endtask

  task automatic run_phase(input int unsigned min_w, input int unsigned max_w,
                           input int unsigned floor_w, input int unsigned margin,
                           input int unsigned base_rtt, input bit no_gaps);
    apply_settings(min_w, max_w, floor_w, margin);
    quiet = no_gaps;
    queue_acks(65, base_rtt);
  endtask

  initial begin
    int unsigned lo;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_WINDOW;
    cfg_data = '0;
    ack_ch.valid = 1'b0;
    ack_ch.send_time = '0;
    ack_ch.ack_time = '0;
    win_ch.ready = 1'b0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero gap, huge gap, wrapped times, margin boundary
    push_ack(32'hFFFF_FFC1, 32'h0000_0000);
    push_ack(32'h0000_0000, 32'hFFFF_FFFF);
    push_ack(32'hFFFF_FFFF, 32'h0000_003E);
    push_ack(32'h0000_0000, 32'h0000_0043);
    push_ack(32'h0000_0004, 32'h0000_0048);
    push_ack(32'h5555_5515, 32'h5555_5555);
    push_ack(32'hAAAA_AA6A, 32'hAAAA_AAAA);
    push_ack(32'hAAAA_AA00, 32'hAAAA_AAAA);
    push_ack(32'h0FFF_FFC0, 32'h1000_0000);

    // window driven to zero, then reciprocal saturates
    apply_settings(0, 255, 0, 1023);
    push_ack(32'h0000_0000, 32'h9000_0000);
    push_ack(32'h8FFF_FFC1, 32'h9000_0001);
    push_ack(32'h8FFF_FFC3, 32'h9000_0003);

    // min above max, margin zero, full floor
    apply_settings(200, 10, 255, 0);
    push_ack(32'h8FFF_FFCA, 32'h9000_0010);
    push_ack(32'h8FFF_FFD1, 32'h9000_0010);

    ack_clock = $urandom;
    run_phase(1, 255, 255, 0, 55, 1'b0);
    run_phase(255, 1, 0, 1023, 40, 1'b0);
    run_phase(0, 255, 0, 2, 25, 1'b1);
    run_phase(2, 60, 10, 8, 12, 1'b0);
    lo = $urandom_range(1, 20);
    run_phase(lo, $urandom_range(lo, 255), $urandom_range(0, 255), $urandom_range(0, 40),
              4, 1'b0);
    lo = $urandom_range(0, 30);
    run_phase(lo, $urandom_range(lo, 255), $urandom_range(0, 255), $urandom_range(0, 1023),
              0, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("%0d acknowledgements sent, %0d windows checked (%0d with queueing)",
             acks_sent, windows_checked, queue_hits);
    $display("%0d register settings applied, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("** delay_based_window_controller: PASSED **");
    end else begin
      $display("** delay_based_window_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout: %0d windows still outstanding", expected_windows.size());
    $display("** delay_based_window_controller: FAILED **");
    $finish;
  end

endmodule
